// File: hdl/ssms_pkg.sv
package ssms_pkg;

  // field widths
  localparam int NumberW  = 32;
  localparam int PointW   = 4;
  localparam int DigitW   = 4;
  localparam int SegW     = 8;
  localparam int PosW     = 3;
  localparam int NumCfgW  = 4;
  localparam int EnableW  = 8;

  // digit store, bounded by the enable lines
  localparam int MaxDigits  = 8;
  localparam int NumSlots   = 8;
  localparam int DigitSlots = (MaxDigits < NumSlots) ? MaxDigits : NumSlots;
  localparam int BcdW       = NumSlots * DigitW;

  // shift-and-add-3 conversion split over stages
  localparam int StepsPerStage = 4;
  localparam int ConvStages    = NumberW / StepsPerStage;

  // apb map
  localparam int AddrW = 4;
  localparam int DataW = 32;

  typedef enum logic [1:0] {
    RegNumDigits  = 2'd0,
    RegSegActHigh = 2'd1,
    RegEnActHigh  = 2'd2,
    RegScanEnable = 2'd3
  } cfg_reg_e;

  // one beat travelling through the conversion stages
  typedef struct packed {
    logic                     wr;
    logic [NumberW-1:0]       bin;
    logic [BcdW-1:0]          bcd;
    logic signed [PointW-1:0] pt;
  } conv_t;

  // one result beat
  typedef struct packed {
    logic [SegW-1:0]    seg;
    logic [EnableW-1:0] en;
    logic [PosW-1:0]    pos;
  } res_t;

  // segment patterns a-g on bits 0-6
  function automatic logic [SegW-1:0] seg_pattern(logic [DigitW-1:0] d);
    logic [SegW-1:0] p;
    case (d)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      default: p = '0;
    endcase
    return p;
  endfunction

  // StepsPerStage shift-and-add-3 steps; digits above the store are dropped
  function automatic conv_t dabble_stage(conv_t c);
    conv_t r;
    r = c;
    for (int s = 0; s < StepsPerStage; s++) begin
      for (int d = 0; d < NumSlots; d++) begin
        if (r.bcd[d*DigitW +: DigitW] >= 4'd5) begin
          r.bcd[d*DigitW +: DigitW] = r.bcd[d*DigitW +: DigitW] + 4'd3;
        end
      end
      {r.bcd, r.bin} = {r.bcd[BcdW-2:0], r.bin, 1'b0};
    end
    return r;
  endfunction

endpackage

// File: hdl/ssms_in_if.sv
interface ssms_in_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic [ssms_pkg::NumberW-1:0]       number;
  logic signed [ssms_pkg::PointW-1:0] point_index;

  modport source (output valid, req_type, number, point_index, input ready);
  modport sink (input valid, req_type, number, point_index, output ready);
endinterface

// File: hdl/ssms_out_if.sv
interface ssms_out_if;
  logic                          valid;
  logic                          ready;
  logic [ssms_pkg::SegW-1:0]     segment_levels;
  logic [ssms_pkg::EnableW-1:0]  digit_enable_levels;
  logic [ssms_pkg::PosW-1:0]     active_position;

  modport source (output valid, segment_levels, digit_enable_levels, active_position,
                  input ready);
  modport sink (input valid, segment_levels, digit_enable_levels, active_position,
                output ready);
endinterface

// File: hdl/seven_segment_mux_scanner.sv
// channel   | dir | content
// ----------+-----+--------------------------------------------------------
// item_i    | in  | req_type, number, point_index (tick or write beat)
// res_o     | out | segment_levels, digit_enable_levels, active_position
// apb       | in  | num_digits, segment_active_high, enable_active_high,
//           |     | scan_enable at byte addresses 0, 4, 8, 12
//
// one beat accepted per cycle while the result side takes results; a beat passes
// one input stage, 8 decimal conversion stages of 4 shift steps each,
// and the result register where digit store and scan state are updated in order.
// an empty stage takes a beat even while later ones are stalled, so bubbles
// close up; a stalled result holds the stages behind it one after another.
// asynchronous active-low reset empties the pipeline, sets the registers to their
// defaults and clears the digit store at once; no clearing pass is needed.
module seven_segment_mux_scanner (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ssms_in_if.sink                      item_i,
  ssms_out_if.source                   res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssms_pkg::AddrW-1:0]   paddr,
  input  logic [ssms_pkg::DataW-1:0]   pwdata,
  output logic [ssms_pkg::DataW-1:0]   prdata,
  output logic                         pready
);

  localparam int Last = ssms_pkg::ConvStages;

  // configuration
  logic [ssms_pkg::NumCfgW-1:0] num_digits_q;
  logic                         seg_act_high_q;
  logic                         en_act_high_q;
  logic                         scan_en_q;

  // display state
  logic [ssms_pkg::PosW-1:0]          pos_q, pos_d;
  logic [ssms_pkg::DigitW-1:0]        digit_q [ssms_pkg::NumSlots];
  logic [ssms_pkg::DigitW-1:0]        digit_d [ssms_pkg::NumSlots];
  logic signed [ssms_pkg::PointW-1:0] point_q, point_d;
  logic [ssms_pkg::SegW-1:0]          held_q, held_d;
  logic                               lit_q, lit_d;

  // pipeline
  ssms_pkg::conv_t stg_q [Last+1];
  logic [Last:0]   stg_v_q;
  logic [Last+1:0] adv_w;
  logic            out_valid_q;
  ssms_pkg::res_t  res_q, res_d;

  logic                         cfg_wr_w;
  ssms_pkg::cfg_reg_e           cfg_idx_w;
  logic                         commit_w;
  logic [ssms_pkg::NumCfgW-1:0] n_w;
  logic [ssms_pkg::NumCfgW-1:0] nxt_w;
  logic [ssms_pkg::SegW-1:0]    pat_w;
  logic [ssms_pkg::EnableW-1:0] onehot_w;

  // apb access
  assign pready    = 1'b1;
  assign cfg_idx_w = ssms_pkg::cfg_reg_e'(paddr[ssms_pkg::AddrW-1:2]);
  assign cfg_wr_w  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    case (cfg_idx_w)
      ssms_pkg::RegNumDigits:  prdata = ssms_pkg::DataW'(num_digits_q);
      ssms_pkg::RegSegActHigh: prdata = ssms_pkg::DataW'(seg_act_high_q);
      ssms_pkg::RegEnActHigh:  prdata = ssms_pkg::DataW'(en_act_high_q);
      ssms_pkg::RegScanEnable: prdata = ssms_pkg::DataW'(scan_en_q);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_digits_q   <= 4'd4;
      seg_act_high_q <= 1'b1;
      en_act_high_q  <= 1'b0;
      scan_en_q      <= 1'b0;
    end else if (cfg_wr_w) begin
      case (cfg_idx_w)
        ssms_pkg::RegNumDigits:  num_digits_q   <= pwdata[ssms_pkg::NumCfgW-1:0];
        ssms_pkg::RegSegActHigh: seg_act_high_q <= pwdata[0];
        ssms_pkg::RegEnActHigh:  en_act_high_q  <= pwdata[0];
        ssms_pkg::RegScanEnable: scan_en_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // stage advance, from the result register backwards
  always_comb begin
    adv_w[Last+1] = !out_valid_q || res_o.ready;
    for (int k = Last; k >= 0; k--) begin
      adv_w[k] = !stg_v_q[k] || adv_w[k+1];
    end
  end

  assign item_i.ready = adv_w[0];
  assign commit_w     = stg_v_q[Last] && adv_w[Last+1];

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= '0;
    end else begin
      if (adv_w[0]) begin
        stg_v_q[0] <= item_i.valid;
      end
      for (int k = 1; k <= Last; k++) begin
        if (adv_w[k]) begin
          stg_v_q[k] <= stg_v_q[k-1];
        end
      end
    end
  end

  // stage payload: input capture then conversion steps
  always_ff @(posedge clk_i) begin
    if (adv_w[0]) begin
      stg_q[0].wr  <= item_i.req_type;
      stg_q[0].bin <= item_i.number;
      stg_q[0].bcd <= '0;
      stg_q[0].pt  <= item_i.point_index;
    end
    for (int k = 1; k <= Last; k++) begin
      if (adv_w[k]) begin
        stg_q[k] <= ssms_pkg::dabble_stage(stg_q[k-1]);
      end
    end
  end

  // effective digit count
  always_comb begin
    n_w = num_digits_q;
    if (num_digits_q == '0) begin
      n_w = 4'd1;
    end else if (num_digits_q > ssms_pkg::NumCfgW'(ssms_pkg::DigitSlots)) begin
      n_w = ssms_pkg::NumCfgW'(ssms_pkg::DigitSlots);
    end
  end

  // state update and result at commit; lit flag cleared when scanning is turned off
  always_comb begin
    pos_d   = pos_q;
    digit_d = digit_q;
    point_d = point_q;
    held_d  = held_q;
    lit_d   = lit_q;
    nxt_w   = {1'b0, pos_q} + 4'd1;
    pat_w   = '0;

    if (commit_w) begin
      if (stg_q[Last].wr) begin
        for (int i = 0; i < ssms_pkg::NumSlots; i++) begin
          if (ssms_pkg::NumCfgW'(i) < n_w) begin
            digit_d[i] = stg_q[Last].bcd[i*ssms_pkg::DigitW +: ssms_pkg::DigitW];
          end
        end
        point_d = stg_q[Last].pt;
      end else if (scan_en_q) begin
        pos_d = (nxt_w >= n_w) ? '0 : nxt_w[ssms_pkg::PosW-1:0];
        pat_w = ssms_pkg::seg_pattern(digit_q[pos_d]);
        if (!point_q[ssms_pkg::PointW-1] && (point_q[ssms_pkg::PosW-1:0] == pos_d)) begin
          pat_w[ssms_pkg::SegW-1] = 1'b1;
        end
        held_d = seg_act_high_q ? pat_w : ~pat_w;
        lit_d  = 1'b1;
      end else begin
        lit_d = 1'b0;
      end
    end

    // turning scanning off clears the lit flag, so later results show the digits dark
    if (cfg_wr_w && (cfg_idx_w == ssms_pkg::RegScanEnable) && !pwdata[0]) begin
      lit_d = 1'b0;
    end

    onehot_w = lit_d ? (ssms_pkg::EnableW'(1) << pos_d) : '0;
    res_d.seg = held_d;
    res_d.en  = en_act_high_q ? onehot_w : ~onehot_w;
    res_d.pos = pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      point_q <= 4'sb1111;
      held_q  <= '0;
      lit_q   <= 1'b0;
      for (int i = 0; i < ssms_pkg::NumSlots; i++) begin
        digit_q[i] <= '0;
      end
    end else begin
      pos_q   <= pos_d;
      point_q <= point_d;
      held_q  <= held_d;
      lit_q   <= lit_d;
      digit_q <= digit_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_w[Last+1]) begin
      out_valid_q <= stg_v_q[Last];
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_w) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid               = out_valid_q;
  assign res_o.segment_levels      = res_q.seg;
  assign res_o.digit_enable_levels = res_q.en;
  assign res_o.active_position     = res_q.pos;

  // a stalled beat in the last stage is not lost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_v_q[Last] && !adv_w[Last+1] |=> stg_v_q[Last])
    else $error("last stage beat dropped while stalled");

  // an enabled tick lights its digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_w && !stg_q[Last].wr && scan_en_q |=> lit_q)
    else $error("enabled tick left no digit lit");

  // a write never moves the scan position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_w && stg_q[Last].wr |=> $stable(pos_q))
    else $error("write beat moved the scan position");

  // an enabled tick drives exactly one active enable line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_w && !stg_q[Last].wr && scan_en_q |=>
      ((en_act_high_q && ($countones(res_q.en) == 1)) ||
       (!en_act_high_q && ($countones(~res_q.en) == 1))))
    else $error("enabled tick result without a single active enable");

endmodule

// File: test/seven_segment_mux_scanner_tb.sv
module seven_segment_mux_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 1300;
  localparam int IdleLimit   = 3000;
  localparam int DrainCycles = 20;
  localparam int ReportMax   = 10;
  localparam logic [3:0] NoPoint = 4'hF;

  // predicts display levels per beat and holds them until the result beat arrives
  class segment_scoreboard;
    logic [7:0] glyph [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                               8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
    logic [3:0] cfg_digits   = 4'd4;
    bit         cfg_seg_high = 1'b1;
    bit         cfg_en_high  = 1'b0;
    bit         cfg_scan     = 1'b0;
    logic [2:0] scan_pos     = '0;
    logic [3:0] digit_store [8] = '{default: 4'd0};
    logic [3:0] point_pos    = NoPoint;
    logic [7:0] held_seg     = 8'h00;
    bit         lit          = 1'b0;
    ssms_pkg::res_t expected_levels [$];
    int         errors       = 0;

    function void write_reg(ssms_pkg::cfg_reg_e idx, logic [31:0] val);
      case (idx)
        ssms_pkg::RegNumDigits:  cfg_digits   = val[3:0];
        ssms_pkg::RegSegActHigh: cfg_seg_high = val[0];
        ssms_pkg::RegEnActHigh:  cfg_en_high  = val[0];
        ssms_pkg::RegScanEnable: begin
          cfg_scan = val[0];
          if (!val[0]) lit = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void predict_beat(bit write_req, logic [31:0] number, logic [3:0] pt);
      int         n;
      int         nxt;
      logic [31:0] v;
      logic [7:0] pat;
      logic [7:0] onehot;
      ssms_pkg::res_t r;
      n = (cfg_digits == 0) ? 1 : (cfg_digits > 8) ? 8 : int'(cfg_digits);
      if (write_req) begin
        // lowest n decimal digits, least significant at position 0
        v = number;
        for (int i = 0; i < n; i++) begin
          digit_store[i] = 4'(v % 10);
          v = v / 10;
        end
        point_pos = pt;
      end else if (cfg_scan) begin
        nxt = int'(scan_pos) + 1;
        if (nxt >= n) nxt = 0;
        scan_pos = 3'(nxt);
        pat = glyph[digit_store[scan_pos]];
        // negative point values never match a position
        if (!point_pos[3] && point_pos[2:0] == scan_pos) pat[7] = 1'b1;
        held_seg = cfg_seg_high ? pat : ~pat;
        lit = 1'b1;
      end else begin
        lit = 1'b0;
      end
      onehot = lit ? (8'd1 << scan_pos) : 8'd0;
      r.seg = held_seg;
      r.en  = cfg_en_high ? onehot : ~onehot;
      r.pos = scan_pos;
      expected_levels.push_back(r);
    endfunction

    function void check_levels(logic [7:0] seg, logic [7:0] en, logic [2:0] pos);
      ssms_pkg::res_t exp_r;
      if (expected_levels.size() == 0) begin
        errors++;
        if (errors <= ReportMax)
          $display("%0t: result beat with nothing expected: seg=%h en=%h pos=%0d",
                   $time, seg, en, pos);
        return;
      end
      exp_r = expected_levels.pop_front();
      if (seg !== exp_r.seg || en !== exp_r.en || pos !== exp_r.pos) begin
        errors++;
        if (errors <= ReportMax)
          $display("%0t: mismatch expected seg=%h en=%h pos=%0d, got seg=%h en=%h pos=%0d",
                   $time, exp_r.seg, exp_r.en, exp_r.pos, seg, en, pos);
      end
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ssms_pkg::AddrW-1:0]  paddr;
  logic [ssms_pkg::DataW-1:0]  pwdata;
  logic [ssms_pkg::DataW-1:0]  prdata;
  logic                        pready;

  ssms_in_if  in_bus ();
  ssms_out_if out_bus ();

  segment_scoreboard sb = new();
  bit calm;
  int hold_left;
  int idle_cycles;

  seven_segment_mux_scanner u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (in_bus),
    .res_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_beat(bit wr, logic [31:0] num, logic [3:0] pt);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid       <= 1'b1;
    in_bus.req_type    <= wr;
    in_bus.number      <= num;
    in_bus.point_index <= pt;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.predict_beat(wr, num, pt);
  endtask

  task automatic apb_write(ssms_pkg::cfg_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stop sending and let every expected beat come out
  task automatic wait_idle();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // result side back-pressure
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      out_bus.ready <= 1'b1;
      hold_left = pick_gap();
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      sb.check_levels(out_bus.segment_levels, out_bus.digit_enable_levels,
                      out_bus.active_position);
  end

  // watchdog on cycles without any beat or register access
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int          sent;
    int          batch;
    int          write_pct;
    int          r;
    logic [31:0] num;
    logic [31:0] p10;
    logic [3:0]  pt;
    logic [3:0]  nd;
    bit          wr;

    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_bus.valid       = 1'b0;
    in_bus.req_type    = 1'b0;
    in_bus.number      = '0;
    in_bus.point_index = '0;
    out_bus.ready      = 1'b0;
    calm               = 1'b0;
    hold_left          = 0;
    idle_cycles        = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: scanning off, ticks hold with all digits dark
    send_beat(1'b0, 32'd0, NoPoint);
    send_beat(1'b1, 32'hFFFF_FFFF, NoPoint);
    send_beat(1'b0, 32'd0, NoPoint);
    wait_idle();

    // all eight digits, point on the top one, a full scan with wrap
    apb_write(ssms_pkg::RegScanEnable, 32'd1);
    apb_write(ssms_pkg::RegNumDigits, 32'd8);
    send_beat(1'b1, 32'hFFFF_FFFF, 4'd7);
    repeat (8) send_beat(1'b0, 32'd0, NoPoint);
    wait_idle();

    // zero digits counts as one, inverted polarities, most negative point
    apb_write(ssms_pkg::RegNumDigits, 32'd0);
    apb_write(ssms_pkg::RegSegActHigh, 32'd0);
    apb_write(ssms_pkg::RegEnActHigh, 32'd1);
    send_beat(1'b1, 32'd0, 4'd0);
    send_beat(1'b0, 32'd0, NoPoint);
    send_beat(1'b0, 32'd0, NoPoint);
    send_beat(1'b1, 32'd9, 4'h8);
    send_beat(1'b0, 32'd0, NoPoint);
    wait_idle();

    // digit count saturates; disabling by register darkens the write result
    apb_write(ssms_pkg::RegNumDigits, 32'd15);
    apb_write(ssms_pkg::RegScanEnable, 32'd0);
    send_beat(1'b1, 32'd12345678, 4'd3);
    send_beat(1'b0, 32'd0, NoPoint);
    wait_idle();

    // short count keeps the upper digits, position wraps at the count
    apb_write(ssms_pkg::RegScanEnable, 32'd1);
    apb_write(ssms_pkg::RegNumDigits, 32'd3);
    send_beat(1'b1, 32'd987, 4'd2);
    repeat (4) send_beat(1'b0, 32'd0, NoPoint);

    // random phases with new settings in between
    sent = 0;
    while (sent < RandomItems) begin
      wait_idle();
      if ($urandom_range(0, 1) == 1) begin
        r  = $urandom_range(0, 9);
        nd = (r == 0) ? 4'd0 : (r == 1) ? 4'd15 : (r == 2) ? 4'($urandom_range(9, 14))
                                                           : 4'($urandom_range(1, 8));
        apb_write(ssms_pkg::RegNumDigits, {28'd0, nd});
      end
      if ($urandom_range(0, 2) == 0)
        apb_write(ssms_pkg::RegSegActHigh, $urandom_range(0, 1));
      if ($urandom_range(0, 2) == 0)
        apb_write(ssms_pkg::RegEnActHigh, $urandom_range(0, 1));
      if ($urandom_range(0, 2) == 0)
        apb_write(ssms_pkg::RegScanEnable, ($urandom_range(0, 99) < 85) ? 32'd1 : 32'd0);

      batch     = $urandom_range(40, 160);
      calm      = ($urandom_range(0, 3) == 0);
      write_pct = $urandom_range(5, 40);
      repeat (batch) begin
        wr = ($urandom_range(0, 99) < write_pct);
        p10 = 32'd1;
        repeat ($urandom_range(0, 9)) p10 = p10 * 10;
        case ($urandom_range(0, 4))
          0:       num = $urandom();
          1:       num = $urandom_range(0, 99);
          2:       num = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
          3:       num = $urandom_range(0, 1) ? p10 : p10 - 1;
          default: num = $urandom() >> $urandom_range(0, 31);
        endcase
        r = $urandom_range(0, 99);
        pt = (r < 30) ? NoPoint : (r < 80) ? 4'($urandom_range(0, 7))
                                           : 4'($urandom_range(0, 15));
        send_beat(wr, num, pt);
        sent++;
      end
    end

    wait_idle();
    calm = 1'b0;
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: seven_segment_mux_scanner.f
hdl/ssms_pkg.sv
hdl/ssms_in_if.sv
hdl/ssms_out_if.sv
hdl/seven_segment_mux_scanner.sv
test/seven_segment_mux_scanner_tb.sv
